// ----- sv/hssc_pkg.sv -----
package hssc_pkg;

  localparam int unsigned GATE_W      = 16;
  localparam int unsigned SECTOR_W    = 3;
  localparam int unsigned PERIOD_W    = 32;
  localparam int unsigned SPEED_W     = 26;
  localparam int unsigned MAP_W       = 24;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned IN_DATA_W   = 8;

  localparam int unsigned SECTOR_LSB  = 6 * GATE_W;
  localparam int unsigned PERIOD_LSB  = SECTOR_LSB + SECTOR_W;
  localparam int unsigned SPEED_LSB   = PERIOD_LSB + PERIOD_W;
  localparam int unsigned PAYLOAD_W   = SPEED_LSB + SPEED_W;
  localparam int unsigned OUT_DATA_W  = ((PAYLOAD_W + 7) / 8) * 8;

  localparam logic [2:0]         LATCH_CODE      = 3'd5;
  localparam logic [SPEED_W-1:0] SPEED_NUMERATOR = 26'd60000000;
  localparam logic [GATE_W-1:0]  FULL_ON_RESET   = 16'hFFFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_DUTY      = 2'd1,
    CFG_FULL_ON   = 2'd2,
    CFG_HALL_MAP  = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_FLOAT,
    PH_POS,
    PH_NEG
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PUSH
  } state_t;

  typedef struct packed {
    phase_t w;
    phase_t v;
    phase_t u;
  } phase_set_t;

  function automatic phase_set_t phase_lookup(input logic dir, input logic [2:0] sector);
    phase_set_t ps;
    ps = '{w: PH_FLOAT, v: PH_FLOAT, u: PH_FLOAT};
    case ({dir, sector})
      4'b0_001: ps = '{w: PH_FLOAT, v: PH_POS,   u: PH_NEG};
      4'b0_010: ps = '{w: PH_POS,   v: PH_FLOAT, u: PH_NEG};
      4'b0_011: ps = '{w: PH_POS,   v: PH_NEG,   u: PH_FLOAT};
      4'b0_100: ps = '{w: PH_FLOAT, v: PH_NEG,   u: PH_POS};
      4'b0_101: ps = '{w: PH_NEG,   v: PH_FLOAT, u: PH_POS};
      4'b0_110: ps = '{w: PH_NEG,   v: PH_POS,   u: PH_FLOAT};
      4'b1_001: ps = '{w: PH_FLOAT, v: PH_NEG,   u: PH_POS};
      4'b1_010: ps = '{w: PH_NEG,   v: PH_FLOAT, u: PH_POS};
      4'b1_011: ps = '{w: PH_NEG,   v: PH_POS,   u: PH_FLOAT};
      4'b1_100: ps = '{w: PH_FLOAT, v: PH_POS,   u: PH_NEG};
      4'b1_101: ps = '{w: PH_POS,   v: PH_FLOAT, u: PH_NEG};
      4'b1_110: ps = '{w: PH_POS,   v: PH_NEG,   u: PH_FLOAT};
      default:  ps = '{w: PH_FLOAT, v: PH_FLOAT, u: PH_FLOAT};
    endcase
    return ps;
  endfunction

endpackage

// ----- sv/hall_six_step_commutator_core.sv -----
// flow: an accepted tick goes straight to the push state, or, if it latches a new nonzero
// period, first through the restoring speed divider (one quotient bit per cycle); the push
// state waits until the output register is free, a new tick is taken only after the last is
// pushed, and a finished result waits in the output register while the next tick is taken
// reset: synchronous active-low rst_n clears the tick count, hall history, latched period
// and speed, and returns the registers to direction 0, duty 0, full-on 65535, map 0
module hall_six_step_commutator_core import hssc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // hall_u, hall_v, hall_w, zero fill
  input  logic [IN_DATA_W-1:0]   in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // u_high_gate, u_low_gate, v_high_gate, v_low_gate, w_high_gate, w_low_gate,
  // sector, period_us, speed_rpm, zero fill
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // speed_updated
  output logic                   out_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(SPEED_W);

  // configuration
  logic              direction_r;
  logic [GATE_W-1:0] duty_r;
  logic [GATE_W-1:0] full_on_r;
  logic [MAP_W-1:0]  hall_map_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      duty_r      <= '0;
      full_on_r   <= FULL_ON_RESET;
      hall_map_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_DIRECTION: direction_r <= cfg_wdata[0];
        CFG_DUTY:      duty_r      <= cfg_wdata[GATE_W-1:0];
        CFG_FULL_ON:   full_on_r   <= cfg_wdata[GATE_W-1:0];
        CFG_HALL_MAP:  hall_map_r  <= cfg_wdata[MAP_W-1:0];
        default: ;
      endcase
    end
  end

  // tick state
  state_t                 state_r, state_nxt;
  logic [2:0]             prev_code_r;
  logic [COUNT_WIDTH-1:0] elapsed_r;
  logic [PERIOD_W-1:0]    period_r;
  logic [SPEED_W-1:0]     speed_r;
  logic [SECTOR_W-1:0]    sector_r;
  logic                   updated_r;

  // divider
  logic [SPEED_W-1:0]     rem_r, rem_nxt;
  logic [SPEED_W-1:0]     num_r;
  logic [SPEED_W-1:0]     quo_r, quo_nxt;
  logic [PERIOD_W-1:0]    div_r;
  logic [CNT_W-1:0]       bit_cnt_r;

  // output register
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   out_user_r;

  logic                   accept;
  logic                   div_active;
  logic                   push_ready;
  logic                   push_fire;
  logic                   div_done;

  logic [2:0]               code;
  logic [SECTOR_W-1:0]      sector_lu;
  logic                     latch;
  logic [COUNT_WIDTH-1:0]   elapsed_inc;
  logic [COUNT_WIDTH+31:0]  cnt_ext;
  logic [PERIOD_W-1:0]      per;

  assign code        = in_tdata[2:0];
  assign sector_lu   = hall_map_r[3*code +: 3];
  assign latch       = (code == LATCH_CODE) && (code != prev_code_r);
  assign elapsed_inc = (elapsed_r != '1) ? elapsed_r + 1'b1 : elapsed_r;
  assign cnt_ext     = {32'd0, elapsed_inc};
  assign per         = (|cnt_ext[COUNT_WIDTH+31:32]) ? '1 : cnt_ext[31:0];

  assign push_ready  = !out_valid_r || out_tready;
  assign div_done    = (bit_cnt_r == CNT_W'(SPEED_W - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (latch && (per != '0)) ? ST_DIV : ST_PUSH;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_tready  = 1'b0;
    div_active = 1'b0;
    push_fire  = 1'b0;
    case (state_r)
      ST_IDLE: in_tready  = 1'b1;
      ST_DIV:  div_active = 1'b1;
      ST_PUSH: push_fire  = push_ready;
      default: ;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // one restoring step per cycle
  logic [SPEED_W:0]    shifted;
  logic [PERIOD_W-1:0] trial;
  logic [PERIOD_W-1:0] diff;

  always_comb begin
    shifted = {rem_r, num_r[SPEED_W-1]};
    trial   = PERIOD_W'(shifted);
    diff    = trial - div_r;
    if (trial >= div_r) begin
      rem_nxt = diff[SPEED_W-1:0];
      quo_nxt = {quo_r[SPEED_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[SPEED_W-1:0];
      quo_nxt = {quo_r[SPEED_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prev_code_r <= '0;
      elapsed_r   <= '0;
      period_r    <= '0;
      speed_r     <= '0;
      updated_r   <= 1'b0;
      bit_cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        prev_code_r <= code;
        updated_r   <= latch;
        bit_cnt_r   <= '0;
        if (latch) begin
          elapsed_r <= '0;
          period_r  <= per;
          if (per == '0) begin
            speed_r <= '0;
          end
        end else begin
          elapsed_r <= elapsed_inc;
        end
      end
      if (div_active) begin
        bit_cnt_r <= bit_cnt_r + 1'b1;
        if (div_done) begin
          speed_r <= quo_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sector_r <= sector_lu;
      rem_r    <= '0;
      num_r    <= SPEED_NUMERATOR;
      quo_r    <= '0;
      div_r    <= per;
    end else if (div_active) begin
      rem_r <= rem_nxt;
      num_r <= {num_r[SPEED_W-2:0], 1'b0};
      quo_r <= quo_nxt;
    end
  end

  // gate compares from the captured sector
  phase_set_t          ps;
  phase_t              ph [3];
  logic [GATE_W-1:0]   gate_hi [3];
  logic [GATE_W-1:0]   gate_lo [3];
  logic [OUT_DATA_W-1:0] out_data_nxt;

  always_comb begin
    ps    = phase_lookup(direction_r, sector_r);
    ph[0] = ps.u;
    ph[1] = ps.v;
    ph[2] = ps.w;
    for (int p = 0; p < 3; p++) begin
      gate_hi[p] = (ph[p] == PH_POS) ? duty_r    : '0;
      gate_lo[p] = (ph[p] == PH_NEG) ? full_on_r : '0;
    end
    out_data_nxt = '0;
    for (int p = 0; p < 3; p++) begin
      out_data_nxt[2*p*GATE_W +: GATE_W]     = gate_hi[p];
      out_data_nxt[(2*p+1)*GATE_W +: GATE_W] = gate_lo[p];
    end
    out_data_nxt[SECTOR_LSB +: SECTOR_W] = sector_r;
    out_data_nxt[PERIOD_LSB +: PERIOD_W] = period_r;
    out_data_nxt[SPEED_LSB +: SPEED_W]   = speed_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      out_data_r <= out_data_nxt;
      out_user_r <= updated_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ----- sv/hssc_checker.sv -----
module hssc_checker import hssc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_DATA_W-1:0]  out_tdata,
  input logic                   out_tuser
);

  logic [SECTOR_W-1:0] sector;
  logic [PERIOD_W-1:0] period;
  logic [SPEED_W-1:0]  speed;

  assign sector = out_tdata[SECTOR_LSB +: SECTOR_W];
  assign period = out_tdata[PERIOD_LSB +: PERIOD_W];
  assign speed  = out_tdata[SPEED_LSB +: SPEED_W];

  // a stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a fresh latch never carries a zero period
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> period != '0)
    else $error("latched period is zero");

  // floating sectors drive no gate
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (sector == 3'd0 || sector == 3'd7) |-> out_tdata[SECTOR_LSB-1:0] == '0)
    else $error("gate driven in floating sector");

  // speed bounded by the numerator, exact at a one-tick period
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> speed <= SPEED_NUMERATOR)
    else $error("speed out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && period == 32'd1 |-> speed == SPEED_NUMERATOR)
    else $error("speed wrong for one-tick period");

endmodule

bind hall_six_step_commutator_core hssc_checker u_hssc_checker (.*);
